// ----- hw/rtl/tct_pkg.sv -----
// Package for the transfer completion tracker.
// Holds widths, table size, request and status codes and the slot entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tct_pkg;

  localparam int unsigned Entries   = 16;
  localparam int unsigned IdxW      = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned LiveW     = $clog2(Entries + 1);
  localparam int unsigned ReqW      = 2;
  localparam int unsigned IdW       = 32;
  localparam int unsigned ExpW      = 20;
  localparam int unsigned BytesW    = 48;
  localparam int unsigned MsW       = 48;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned RateW     = 58;
  localparam int unsigned LiveOutW  = 5;
  localparam int unsigned DivSteps  = RateW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  typedef enum logic [ReqW-1:0] {
    REQ_GEN  = 2'd0,
    REQ_ADD  = 2'd1,
    REQ_CONS = 2'd2
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_DONE    = 3'd1,
    ST_DUP     = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ExpW-1:0]   remaining;
    logic [BytesW-1:0] bytes;
    logic [MsW-1:0]    start_ms;
  } entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tct_if.sv -----
// Handshake interfaces for the tracker's request and response transfers.
// Depends on tct_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tct_req_if import tct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ReqW-1:0]     req_type;
  logic [IdW-1:0]      sub_id;
  logic [ExpW-1:0]     expected_responses;
  logic [BytesW-1:0]   byte_total;
  logic [MsW-1:0]      now_ms;

  modport source (output valid, req_type, sub_id, expected_responses, byte_total, now_ms,
                  input ready);
  modport sink   (input valid, req_type, sub_id, expected_responses, byte_total, now_ms,
                  output ready);
endinterface

interface tct_rsp_if import tct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [IdW-1:0]      new_id;
  logic [BytesW-1:0]   done_bytes;
  logic [MsW-1:0]      span_ms;
  logic [RateW-1:0]    rate_bps;
  logic [LiveOutW-1:0] live_count;

  modport source (output valid, status, new_id, done_bytes, span_ms, rate_bps, live_count,
                  input ready);
  modport sink   (input valid, status, new_id, done_bytes, span_ms, rate_bps, live_count,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tct_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/transfer_completion_tracker.sv -----
// Transfer completion tracker: slot table in a RAM, walked one entry at a time (read, then check).
// Add and consume answer after a walk that runs until a hit or the end of the table;
// generate walks the table once per candidate id tried, until an id is unused. A completing
// consume also computes the rate with a multiply and a 58-step serial division.
// An unused request type goes straight to the response.
// One request at a time; a new transfer is taken while a response waits.
// Reset clears the valid bits, live count and id counter at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module transfer_completion_tracker import tct_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  tct_req_if.sink  req_i,
  tct_rsp_if.source rsp_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_GEN  = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_ACT  = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_RSP  = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [ReqW-1:0]     req_q, req_d;
  logic [IdW-1:0]      key_q, key_d;
  logic [ExpW-1:0]     exp_q, exp_d;
  logic [BytesW-1:0]   bytes_q, bytes_d;
  logic [MsW-1:0]      now_q, now_d;
  logic [IdW-1:0]      cnt_q, cnt_d;
  logic [Entries-1:0]  valid_q, valid_d;
  logic [LiveW-1:0]    live_q, live_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                hit_q, hit_d;
  logic                free_ok_q, free_ok_d;
  logic [IdxW-1:0]     free_idx_q, free_idx_d;
  status_e             st_q, st_d;
  logic [IdW-1:0]      new_id_q, new_id_d;
  logic [BytesW-1:0]   done_q, done_d;
  logic [MsW-1:0]      elapsed_q, elapsed_d;
  logic [RateW-1:0]    div_n_q, div_n_d;
  logic [MsW-1:0]      div_r_q, div_r_d;
  logic [DivCntW-1:0]  div_cnt_q, div_cnt_d;

  logic                rsp_valid_q, rsp_valid_d;
  status_e             rsp_st_q, rsp_st_d;
  logic [IdW-1:0]      rsp_id_q, rsp_id_d;
  logic [BytesW-1:0]   rsp_bytes_q, rsp_bytes_d;
  logic [MsW-1:0]      rsp_ms_q, rsp_ms_d;
  logic [RateW-1:0]    rsp_rate_q, rsp_rate_d;
  logic [LiveOutW-1:0] rsp_live_q, rsp_live_d;

  logic                ram_we, ram_re;
  logic [IdxW-1:0]     ram_waddr;
  entry_t              ram_wdata, ram_rdata;
  logic [ExpW-1:0]     rem_dec;
  logic [MsW:0]        div_trial;
  logic [MsW:0]        div_diff;
  logic [RateW-1:0]    done_ext;
  logic                req_fire;

  tct_ram #(
    .Width ($bits(entry_t)),
    .Depth (Entries)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  assign rem_dec   = ram_rdata.remaining - ExpW'(1);
  assign div_trial = {div_r_q, div_n_q[RateW-1]};
  assign div_diff  = div_trial - {1'b0, elapsed_q};
  assign done_ext  = RateW'(done_q);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    key_d       = key_q;
    exp_d       = exp_q;
    bytes_d     = bytes_q;
    now_d       = now_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    live_d      = live_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    free_ok_d   = free_ok_q;
    free_idx_d  = free_idx_q;
    st_d        = st_q;
    new_id_d    = new_id_q;
    done_d      = done_q;
    elapsed_d   = elapsed_q;
    div_n_d     = div_n_q;
    div_r_d     = div_r_q;
    div_cnt_d   = div_cnt_q;
    rsp_valid_d = rsp_valid_q;
    rsp_st_d    = rsp_st_q;
    rsp_id_d    = rsp_id_q;
    rsp_bytes_d = rsp_bytes_q;
    rsp_ms_d    = rsp_ms_q;
    rsp_rate_d  = rsp_rate_q;
    rsp_live_d  = rsp_live_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = ram_rdata;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          req_d      = req_i.req_type;
          key_d      = req_i.sub_id;
          exp_d      = req_i.expected_responses;
          bytes_d    = req_i.byte_total;
          now_d      = req_i.now_ms;
          st_d       = ST_OK;
          new_id_d   = '0;
          done_d     = '0;
          elapsed_d  = '0;
          div_n_d    = '0;
          idx_d      = '0;
          hit_d      = 1'b0;
          free_ok_d  = 1'b0;
          free_idx_d = '0;
          unique case (req_i.req_type)
            REQ_GEN:            state_d = S_GEN;
            REQ_ADD, REQ_CONS:  state_d = S_RD;
            default:            state_d = S_RSP;
          endcase
        end
      end
      S_GEN: begin
        if (cnt_q == '0) begin
          key_d = IdW'(1);
          cnt_d = IdW'(2);
        end else begin
          key_d = cnt_q;
          cnt_d = cnt_q + IdW'(1);
        end
        idx_d   = '0;
        hit_d   = 1'b0;
        state_d = S_RD;
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (!valid_q[idx_q] && !free_ok_q) begin
          free_ok_d  = 1'b1;
          free_idx_d = idx_q;
        end
        if (valid_q[idx_q] && ram_rdata.id == key_q) begin
          hit_d   = 1'b1;
          state_d = S_ACT;
        end else if (idx_q == IdxW'(Entries - 1)) begin
          state_d = S_ACT;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = S_RD;
        end
      end
      S_ACT: begin
        unique case (req_q)
          REQ_GEN: begin
            if (hit_q) begin
              state_d = S_GEN;
            end else begin
              new_id_d = key_q;
              state_d  = S_RSP;
            end
          end
          REQ_ADD: begin
            state_d = S_RSP;
            if (hit_q) begin
              st_d = ST_DUP;
            end else if (!free_ok_q) begin
              st_d = ST_FULL;
            end else begin
              ram_we              = 1'b1;
              ram_waddr           = free_idx_q;
              ram_wdata.id        = key_q;
              ram_wdata.remaining = exp_q;
              ram_wdata.bytes     = bytes_q;
              ram_wdata.start_ms  = now_q;
              valid_d[free_idx_q] = 1'b1;
              live_d              = live_q + LiveW'(1);
            end
          end
          default: begin
            state_d = S_RSP;
            if (!hit_q) begin
              st_d = ST_UNKNOWN;
            end else if (rem_dec != '0) begin
              ram_we              = 1'b1;
              ram_wdata.remaining = rem_dec;
            end else begin
              st_d           = ST_DONE;
              valid_d[idx_q] = 1'b0;
              live_d         = live_q - LiveW'(1);
              done_d         = ram_rdata.bytes;
              elapsed_d      = (now_q >= ram_rdata.start_ms) ?
                               (now_q - ram_rdata.start_ms) : '0;
              state_d        = S_MUL;
            end
          end
        endcase
      end
      S_MUL: begin
        div_r_d   = '0;
        div_cnt_d = '0;
        if (elapsed_q == '0) begin
          div_n_d = '0;
          state_d = S_RSP;
        end else begin
          div_n_d = (done_ext << 10) - (done_ext << 4) - (done_ext << 3);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_diff[MsW]) begin
          div_r_d = div_diff[MsW-1:0];
          div_n_d = {div_n_q[RateW-2:0], 1'b1};
        end else begin
          div_r_d = div_trial[MsW-1:0];
          div_n_d = {div_n_q[RateW-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + DivCntW'(1);
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = S_RSP;
        end
      end
      S_RSP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_st_d    = st_q;
          rsp_id_d    = new_id_q;
          rsp_bytes_d = done_q;
          rsp_ms_d    = elapsed_q;
          rsp_rate_d  = div_n_q;
          rsp_live_d  = LiveOutW'(live_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      live_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      live_q      <= live_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    key_q       <= key_d;
    exp_q       <= exp_d;
    bytes_q     <= bytes_d;
    now_q       <= now_d;
    idx_q       <= idx_d;
    hit_q       <= hit_d;
    free_ok_q   <= free_ok_d;
    free_idx_q  <= free_idx_d;
    st_q        <= st_d;
    new_id_q    <= new_id_d;
    done_q      <= done_d;
    elapsed_q   <= elapsed_d;
    div_n_q     <= div_n_d;
    div_r_q     <= div_r_d;
    div_cnt_q   <= div_cnt_d;
    rsp_st_q    <= rsp_st_d;
    rsp_id_q    <= rsp_id_d;
    rsp_bytes_q <= rsp_bytes_d;
    rsp_ms_q    <= rsp_ms_d;
    rsp_rate_q  <= rsp_rate_d;
    rsp_live_q  <= rsp_live_d;
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_st_q;
  assign rsp_o.new_id     = rsp_id_q;
  assign rsp_o.done_bytes = rsp_bytes_q;
  assign rsp_o.span_ms    = rsp_ms_q;
  assign rsp_o.rate_bps   = rsp_rate_q;
  assign rsp_o.live_count = rsp_live_q;

  a_live_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(live_q) == $countones(valid_q))
    else $error("live count differs from valid slots");

  a_write_only_in_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_ACT))
    else $error("slot write outside update step");

  a_no_read_write_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("slot read and write in one cycle");

  a_div_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (32'(div_cnt_q) < DivSteps))
    else $error("divider ran past its step count");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(req_fire) |-> !req_i.ready)
    else $error("second transfer taken while busy");

endmodule
`default_nettype wire
